>>> sv/hs_pkg.sv
// heap sorter package: field widths, datapath op codes and sequencer status bundle
// no dependencies; compiled first
`default_nettype none

package hs_pkg;

  localparam int IO_W = 32;

  // datapath operation selected by the current control word
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_BUILD_RD,
    OP_TAKE_NV,
    OP_SIFT_RD,
    OP_SIFT_SEL,
    OP_SIFT_MOVE,
    OP_PUT_NV,
    OP_DEC_I,
    OP_SORT_INIT,
    OP_SORT_RD,
    OP_SORT_SWAP,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_LOAD,
    OP_CLEAR
  } hs_op_t;

  // datapath status seen by the sequencer's jump conditions
  typedef struct packed {
    logic acc_last;
    logic small_run;
    logic no_child;
    logic less;
    logic sorting;
    logic i_zero;
    logic i_one;
    logic out_busy;
    logic k_more;
  } hs_stat_t;

endpackage

`default_nettype wire

>>> sv/hs_stream_if.sv
// valid/ready channels of the heap sorter: input items and sorted results
// depends on hs_pkg for the field width
`default_nettype none

interface hs_in_if;
  import hs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] value;
  logic                   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
  modport mon    (input valid, input value, input last, input ready);
endinterface

interface hs_out_if;
  import hs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] sorted_value;
  logic                   final_res;
  logic                   overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
  modport mon    (input valid, input sorted_value, input final_res, input overflow,
                  input ready);
endinterface

`default_nettype wire

>>> sv/heap_sorter_unit.sv
// Heap sorter. Items stream in one per cycle into a local element store until an item with
// last set arrives; elements past MAX_ELEMS are dropped and the whole run reports overflow.
// The stored run is then heap-sorted in place and sent out in ascending order, final_res set
// on the greatest element. Input is closed from the last item of a run until the final result
// has been transferred and the sequencer has passed its clear step. Sorting runs from a
// small control store driving one store with one write and two read ports: each tree level
// that a sift-down descends takes a read, a select and a compare step, and a sift-down stops
// once its value is not less than the larger child or it has no child. Each result is read,
// loaded into the output register and taken by the sink before the next result is read.
// Store contents need no clearing after reset.
// depends on hs_pkg, hs_stream_if and hs_useq
`default_nettype none

module heap_sorter_unit #(
  parameter int MAX_ELEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire     clk,
  input  wire     rst_n,
  hs_in_if.sink   in_ch,
  hs_out_if.source out_ch
);
  import hs_pkg::*;

  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int DW = DATA_WIDTH;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic signed [DW-1:0] data_t;

  hs_op_t   op;
  hs_stat_t stat;

  data_t mem [MAX_ELEMS];
  data_t rd0_r, rd1_r;
  addr_t ra0, ra1;
  logic  mem_we;
  addr_t mem_wa;
  data_t mem_wd;

  cnt_t  count_r, count_nxt;
  logic  ovf_r, ovf_nxt;
  logic  sorting_r, sorting_nxt;
  addr_t i_r, i_nxt;
  addr_t bottom_r, bottom_nxt;
  addr_t node_r, node_nxt;
  addr_t cidx_r, cidx_nxt;
  data_t nv_r, nv_nxt;
  data_t cv_r, cv_nxt;
  cnt_t  k_r, k_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic signed [IO_W-1:0] out_val_r, out_val_nxt;
  logic                   out_fin_r, out_fin_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic [AW:0]            child_w;
  logic                   child_is_bottom;
  addr_t                  child_lo, child_hi;
  data_t                  lo_val;
  logic                   take_hi;
  data_t                  in_data_w;
  logic signed [IO_W-1:0] out_data_w;
  logic                   in_ready, in_acc;

  generate
    if (DW <= IO_W) begin : g_in_narrow
      assign in_data_w = in_ch.value[DW-1:0];
    end else begin : g_in_wide
      assign in_data_w = {{(DW-IO_W){in_ch.value[IO_W-1]}}, in_ch.value};
    end
    if (DW >= IO_W) begin : g_out_wide
      assign out_data_w = rd0_r[IO_W-1:0];
    end else begin : g_out_narrow
      assign out_data_w = {{(IO_W-DW){1'b0}}, rd0_r};
    end
  endgenerate

  // tree quirk: node 0 has itself and 1 as children; node i has 2i and 2i+1
  assign child_w         = {node_r, 1'b0};
  assign child_is_bottom = (child_w == {1'b0, bottom_r});
  assign child_lo        = child_w[AW-1:0];
  assign child_hi        = child_is_bottom ? child_lo : addr_t'(child_lo + 1'b1);
  // the node's own value lives in nv_r, its store slot is stale
  assign lo_val          = (node_r == '0) ? nv_r : rd0_r;
  assign take_hi         = ~child_is_bottom && !(lo_val > rd1_r);

  assign in_ready = (op == OP_LOAD);
  assign in_acc   = in_ch.valid & in_ready;

  assign stat.acc_last  = in_acc & in_ch.last;
  assign stat.small_run = (count_r < cnt_t'(2));
  assign stat.no_child  = (child_w > {1'b0, bottom_r});
  assign stat.less      = (nv_r < cv_r);
  assign stat.sorting   = sorting_r;
  assign stat.i_zero    = (i_r == '0);
  assign stat.i_one     = (i_r == addr_t'(1));
  assign stat.out_busy  = out_valid_r & ~out_ch.ready;
  assign stat.k_more    = (k_r != count_r);

  hs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    sorting_nxt   = sorting_r;
    i_nxt         = i_r;
    bottom_nxt    = bottom_r;
    node_nxt      = node_r;
    cidx_nxt      = cidx_r;
    nv_nxt        = nv_r;
    cv_nxt        = cv_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_val_nxt   = out_val_r;
    out_fin_nxt   = out_fin_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_wa        = node_r;
    mem_wd        = nv_r;
    ra0           = child_lo;
    ra1           = child_hi;
    case (op)
      OP_LOAD: begin
        if (in_acc) begin
          if (count_r < cnt_t'(MAX_ELEMS)) begin
            mem_we    = 1'b1;
            mem_wa    = count_r[AW-1:0];
            mem_wd    = in_data_w;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_SETUP: begin
        i_nxt       = addr_t'(count_r >> 1);
        bottom_nxt  = addr_t'(count_r - 1'b1);
        sorting_nxt = 1'b0;
      end
      OP_BUILD_RD: begin
        ra0      = i_r;
        node_nxt = i_r;
      end
      OP_TAKE_NV: begin
        nv_nxt = rd0_r;
      end
      OP_SIFT_SEL: begin
        cv_nxt   = take_hi ? rd1_r : lo_val;
        cidx_nxt = take_hi ? child_hi : child_lo;
      end
      OP_SIFT_MOVE: begin
        if (nv_r < cv_r) begin
          mem_we   = 1'b1;
          mem_wa   = node_r;
          mem_wd   = cv_r;
          node_nxt = cidx_r;
        end
      end
      OP_PUT_NV: begin
        mem_we = 1'b1;
      end
      OP_DEC_I: begin
        i_nxt = i_r - 1'b1;
      end
      OP_SORT_INIT: begin
        i_nxt       = addr_t'(count_r - 1'b1);
        sorting_nxt = 1'b1;
      end
      OP_SORT_RD: begin
        ra0        = '0;
        ra1        = i_r;
        node_nxt   = '0;
        bottom_nxt = i_r - 1'b1;
      end
      OP_SORT_SWAP: begin
        // old root goes to the tail, tail value becomes the new root
        mem_we = 1'b1;
        mem_wa = i_r;
        mem_wd = rd0_r;
        nv_nxt = rd1_r;
      end
      OP_EMIT_INIT: begin
        k_nxt = '0;
      end
      OP_EMIT_RD: begin
        ra0 = k_r[AW-1:0];
      end
      OP_EMIT_LOAD: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = out_data_w;
        out_fin_nxt   = ((k_r + 1'b1) == count_r);
        out_ovf_nxt   = ovf_r;
        k_nxt         = k_r + 1'b1;
      end
      OP_CLEAR: begin
        count_nxt   = '0;
        ovf_nxt     = 1'b0;
        sorting_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // element store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sorting_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sorting_r   <= sorting_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    bottom_r  <= bottom_nxt;
    node_r    <= node_nxt;
    cidx_r    <= cidx_nxt;
    nv_r      <= nv_nxt;
    cv_r      <= cv_nxt;
    k_r       <= k_nxt;
    out_val_r <= out_val_nxt;
    out_fin_r <= out_fin_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.final_res    = out_fin_r;
  assign out_ch.overflow     = out_ovf_r;

endmodule

`default_nettype wire

>>> sv/hs_useq.sv
// heap sorter sequencer: step counter, control store and jump logic
// depends on hs_pkg for op codes and the status bundle
`default_nettype none

module hs_useq (
  input  wire              clk,
  input  wire              rst_n,
  input  hs_pkg::hs_stat_t stat,
  output hs_pkg::hs_op_t   op
);
  import hs_pkg::*;

  typedef logic [4:0] step_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_WAIT_LAST,
    C_SMALL,
    C_NO_CHILD,
    C_LESS,
    C_SORTING,
    C_I_NONZERO,
    C_I_NOT_ONE,
    C_OUT_BUSY,
    C_K_MORE
  } cond_t;

  typedef struct packed {
    hs_op_t op;
    cond_t  cond;
    step_t  jmp;
  } uword_t;

  localparam step_t ST_IDLE       = 5'd0;
  localparam step_t ST_SETUP      = 5'd1;
  localparam step_t ST_BUILD_RD   = 5'd2;
  localparam step_t ST_BUILD_NV   = 5'd3;
  localparam step_t ST_SIFT_RD    = 5'd4;
  localparam step_t ST_SIFT_SEL   = 5'd5;
  localparam step_t ST_SIFT_CMP   = 5'd6;
  localparam step_t ST_SIFT_END   = 5'd7;
  localparam step_t ST_BUILD_NEXT = 5'd8;
  localparam step_t ST_SORT_INIT  = 5'd9;
  localparam step_t ST_SORT_RD    = 5'd10;
  localparam step_t ST_SORT_SWAP  = 5'd11;
  localparam step_t ST_SORT_NEXT  = 5'd12;
  localparam step_t ST_EMIT_INIT  = 5'd13;
  localparam step_t ST_EMIT_RD    = 5'd14;
  localparam step_t ST_EMIT_LOAD  = 5'd15;
  localparam step_t ST_EMIT_WAIT  = 5'd16;
  localparam step_t ST_EMIT_NEXT  = 5'd17;
  localparam step_t ST_DONE       = 5'd18;

  // control store: jump to jmp when cond holds, else fall through
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{OP_NONE, C_ALWAYS, ST_IDLE};
    case (s)
      ST_IDLE:       w = '{OP_LOAD,      C_WAIT_LAST, ST_IDLE};
      ST_SETUP:      w = '{OP_SETUP,     C_SMALL,     ST_EMIT_INIT};
      ST_BUILD_RD:   w = '{OP_BUILD_RD,  C_NEVER,     ST_IDLE};
      ST_BUILD_NV:   w = '{OP_TAKE_NV,   C_NEVER,     ST_IDLE};
      ST_SIFT_RD:    w = '{OP_SIFT_RD,   C_NO_CHILD,  ST_SIFT_END};
      ST_SIFT_SEL:   w = '{OP_SIFT_SEL,  C_NEVER,     ST_IDLE};
      ST_SIFT_CMP:   w = '{OP_SIFT_MOVE, C_LESS,      ST_SIFT_RD};
      ST_SIFT_END:   w = '{OP_PUT_NV,    C_SORTING,   ST_SORT_NEXT};
      ST_BUILD_NEXT: w = '{OP_DEC_I,     C_I_NONZERO, ST_BUILD_RD};
      ST_SORT_INIT:  w = '{OP_SORT_INIT, C_NEVER,     ST_IDLE};
      ST_SORT_RD:    w = '{OP_SORT_RD,   C_NEVER,     ST_IDLE};
      ST_SORT_SWAP:  w = '{OP_SORT_SWAP, C_ALWAYS,    ST_SIFT_RD};
      ST_SORT_NEXT:  w = '{OP_DEC_I,     C_I_NOT_ONE, ST_SORT_RD};
      ST_EMIT_INIT:  w = '{OP_EMIT_INIT, C_NEVER,     ST_IDLE};
      ST_EMIT_RD:    w = '{OP_EMIT_RD,   C_NEVER,     ST_IDLE};
      ST_EMIT_LOAD:  w = '{OP_EMIT_LOAD, C_NEVER,     ST_IDLE};
      ST_EMIT_WAIT:  w = '{OP_NONE,      C_OUT_BUSY,  ST_EMIT_WAIT};
      ST_EMIT_NEXT:  w = '{OP_NONE,      C_K_MORE,    ST_EMIT_RD};
      ST_DONE:       w = '{OP_CLEAR,     C_ALWAYS,    ST_IDLE};
      default:       w = '{OP_NONE,      C_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = ucode(step_r);
    case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_WAIT_LAST: take = ~stat.acc_last;
      C_SMALL:     take = stat.small_run;
      C_NO_CHILD:  take = stat.no_child;
      C_LESS:      take = stat.less;
      C_SORTING:   take = stat.sorting;
      C_I_NONZERO: take = ~stat.i_zero;
      C_I_NOT_ONE: take = ~stat.i_one;
      C_OUT_BUSY:  take = stat.out_busy;
      C_K_MORE:    take = stat.k_more;
      default:     take = 1'b1;
    endcase
    step_nxt = take ? uw.jmp : step_t'(step_r + 1'b1);
  end

  assign op = uw.op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/hs_checker.sv
// port-level checks for heap_sorter_unit, attached by bind
// depends on hs_stream_if
`default_nettype none

module hs_checker (
  input  wire      clk,
  input  wire      rst_n,
  hs_in_if.sink    in_ch,
  hs_out_if.source out_ch
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.sorted_value) &&
      $stable(out_ch.final_res) && $stable(out_ch.overflow))
    else $error("result changed while stalled");

  // loading and emission never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  // the last item of a run closes the input to further items
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last |=> !in_ch.ready)
    else $error("input still open after last item");

  // nothing follows the end-of-run result
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.final_res |=> !out_ch.valid)
    else $error("result after end of run");

endmodule

bind heap_sorter_unit hs_checker u_hs_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire
